@@ src/linear_layer_forward_backward_defines.svh @@
// ----------------------------------------------------------------------------
// Linear layer engine: assertion macros
// Shared concurrent assertion forms used by the engine's RTL modules.
// ----------------------------------------------------------------------------
`ifndef LINEAR_LAYER_FORWARD_BACKWARD_DEFINES_SVH
`define LINEAR_LAYER_FORWARD_BACKWARD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LLFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LLFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/llfb_pkg.sv @@
// ----------------------------------------------------------------------------
// llfb_pkg
// Types, codes and constants shared by the linear layer engine modules.
// ----------------------------------------------------------------------------
package llfb_pkg;

    // Default store sizes
    localparam int MAX_ROWS_DEF    = 16;
    localparam int MAX_COLUMNS_DEF = 16;
    localparam int MAX_INNER_DEF   = 16;

    // Field and register widths
    localparam int KIND_W       = 3;
    localparam int INDEX_W      = 4;
    localparam int VALUE_W      = 16;
    localparam int RESULT_W     = 32;
    localparam int STATUS_W     = 2;
    localparam int SIZE_W       = 5;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 5;
    localparam int STORE_ADDR_W = 16;
    localparam int PROD_W       = 32;
    localparam int ACC_W        = 40;
    localparam int BOUND_W      = 9;

    // Command queue depth
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_X  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_W  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD_G  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_Y  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ_DX = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ_DW = 3'd6;
    localparam logic [KIND_W-1:0] KIND_READ_DB = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IN_GRAD_EN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WT_GRAD_EN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_GRAD_EN = 3'd5;

    // One in Q8.8, used to scale sums of G to Q16.16
    localparam logic signed [VALUE_W-1:0] Q88_ONE = 16'sh0100;

    // Input request payload
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [INDEX_W-1:0]        first_index;
        logic [INDEX_W-1:0]        second_index;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    // Result payload
    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic [STATUS_W-1:0]        status;
        logic [INDEX_W-1:0]         echo_first;
        logic [INDEX_W-1:0]         echo_second;
    } t_out_item;

    // Configuration register file contents
    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] columns;
        logic [SIZE_W-1:0] inner;
        logic              in_grad_en;
        logic              wt_grad_en;
        logic              bias_grad_en;
    } t_cfg;

    // Classified command passed from front to back
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [STATUS_W-1:0]       status;
        logic [INDEX_W-1:0]        echo_first;
        logic [INDEX_W-1:0]        echo_second;
        logic signed [VALUE_W-1:0] value;
        logic                      store_we;
        logic [SIZE_W-1:0]         count;
        logic [STORE_ADDR_W-1:0]   addr_x;
        logic [STORE_ADDR_W-1:0]   addr_w;
        logic [STORE_ADDR_W-1:0]   addr_g;
    } t_cmd;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

@@ src/llfb_front.sv @@
// ----------------------------------------------------------------------------
// llfb_front
// Accepts requests, checks them against the configuration and turns each
// into a command: store write address, or walk start addresses and length.
// ----------------------------------------------------------------------------
module llfb_front #(
    parameter int MAX_ROWS    = llfb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = llfb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_INNER   = llfb_pkg::MAX_INNER_DEF
) (
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  llfb_pkg::t_in_item    i_in_data,
    input  llfb_pkg::t_cfg        i_cfg,
    input  llfb_pkg::t_queue_stat i_queue,
    output logic                  o_push,
    output llfb_pkg::t_cmd        o_cmd
);

    localparam logic [llfb_pkg::BOUND_W-1:0] MR_B = llfb_pkg::BOUND_W'(MAX_ROWS);
    localparam logic [llfb_pkg::BOUND_W-1:0] MC_B = llfb_pkg::BOUND_W'(MAX_COLUMNS);
    localparam logic [llfb_pkg::BOUND_W-1:0] MI_B = llfb_pkg::BOUND_W'(MAX_INNER);
    localparam logic [llfb_pkg::STORE_ADDR_W-1:0] MC_A =
        llfb_pkg::STORE_ADDR_W'(MAX_COLUMNS);
    localparam logic [llfb_pkg::STORE_ADDR_W-1:0] MI_A =
        llfb_pkg::STORE_ADDR_W'(MAX_INNER);

    // Map a size register onto 1..max
    function automatic logic [llfb_pkg::SIZE_W-1:0] clamp_size(
        input logic [llfb_pkg::SIZE_W-1:0]  v,
        input logic [llfb_pkg::BOUND_W-1:0] maxv
    );
        logic [llfb_pkg::SIZE_W-1:0] r;
        if (v == '0) begin
            r = llfb_pkg::SIZE_W'(1);
        end else if (llfb_pkg::BOUND_W'(v) > maxv) begin
            r = maxv[llfb_pkg::SIZE_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [llfb_pkg::SIZE_W-1:0]       w_nr;
    logic [llfb_pkg::SIZE_W-1:0]       w_nc;
    logic [llfb_pkg::SIZE_W-1:0]       w_nk;
    logic [llfb_pkg::BOUND_W-1:0]      w_a_b;
    logic [llfb_pkg::BOUND_W-1:0]      w_b_b;
    logic [llfb_pkg::STORE_ADDR_W-1:0] w_a;
    logic [llfb_pkg::STORE_ADDR_W-1:0] w_b;
    logic [llfb_pkg::STORE_ADDR_W-1:0] w_a_mi;
    logic [llfb_pkg::STORE_ADDR_W-1:0] w_a_mc;
    logic [llfb_pkg::STORE_ADDR_W-1:0] w_b_mc;

    // Accept whenever the queue has room
    assign o_in_ready = !i_queue.full;
    assign o_push     = i_in_valid && o_in_ready;

    // Effective sizes and row offsets
    always_comb begin
        w_nr   = clamp_size(i_cfg.rows, MR_B);
        w_nc   = clamp_size(i_cfg.columns, MC_B);
        w_nk   = clamp_size(i_cfg.inner, MI_B);
        w_a_b  = llfb_pkg::BOUND_W'(i_in_data.first_index);
        w_b_b  = llfb_pkg::BOUND_W'(i_in_data.second_index);
        w_a    = llfb_pkg::STORE_ADDR_W'(i_in_data.first_index);
        w_b    = llfb_pkg::STORE_ADDR_W'(i_in_data.second_index);
        w_a_mi = w_a * MI_A;
        w_a_mc = w_a * MC_A;
        w_b_mc = w_b * MC_A;
    end

    // Classify the request
    always_comb begin
        o_cmd             = '0;
        o_cmd.kind        = i_in_data.kind;
        o_cmd.status      = llfb_pkg::STATUS_OK;
        o_cmd.echo_first  = i_in_data.first_index;
        o_cmd.echo_second = i_in_data.second_index;
        o_cmd.value       = i_in_data.value;
        o_cmd.count       = llfb_pkg::SIZE_W'(1);
        case (i_in_data.kind)
            llfb_pkg::KIND_LOAD_X: begin
                o_cmd.store_we = (w_a_b < MR_B) && (w_b_b < MI_B);
                o_cmd.addr_x   = w_a_mi + w_b;
            end
            llfb_pkg::KIND_LOAD_W: begin
                o_cmd.store_we = (w_a_b < MI_B) && (w_b_b < MC_B);
                o_cmd.addr_w   = w_a_mc + w_b;
            end
            llfb_pkg::KIND_LOAD_B: begin
                o_cmd.store_we = (w_b_b < MC_B);
                o_cmd.addr_w   = w_b;
            end
            llfb_pkg::KIND_LOAD_G: begin
                o_cmd.store_we = (w_a_b < MR_B) && (w_b_b < MC_B);
                o_cmd.addr_g   = w_a_mc + w_b;
            end
            llfb_pkg::KIND_READ_Y: begin
                if ((llfb_pkg::SIZE_W'(i_in_data.first_index) >= w_nr) ||
                    (llfb_pkg::SIZE_W'(i_in_data.second_index) >= w_nc)) begin
                    o_cmd.status = llfb_pkg::STATUS_RANGE;
                end
                o_cmd.addr_x = w_a_mi;
                o_cmd.addr_w = w_b;
                o_cmd.count  = w_nk;
            end
            llfb_pkg::KIND_READ_DX: begin
                if (!i_cfg.in_grad_en) begin
                    o_cmd.status = llfb_pkg::STATUS_DISABLED;
                end else if ((llfb_pkg::SIZE_W'(i_in_data.first_index) >= w_nr) ||
                             (llfb_pkg::SIZE_W'(i_in_data.second_index) >= w_nk)) begin
                    o_cmd.status = llfb_pkg::STATUS_RANGE;
                end
                o_cmd.addr_g = w_a_mc;
                o_cmd.addr_w = w_b_mc;
                o_cmd.count  = w_nc;
            end
            llfb_pkg::KIND_READ_DW: begin
                if (!i_cfg.wt_grad_en) begin
                    o_cmd.status = llfb_pkg::STATUS_DISABLED;
                end else if ((llfb_pkg::SIZE_W'(i_in_data.first_index) >= w_nk) ||
                             (llfb_pkg::SIZE_W'(i_in_data.second_index) >= w_nc)) begin
                    o_cmd.status = llfb_pkg::STATUS_RANGE;
                end
                o_cmd.addr_x = w_a;
                o_cmd.addr_g = w_b;
                o_cmd.count  = w_nr;
            end
            default: begin
                // bias gradient: column sum of G, row index not used
                o_cmd.echo_first = '0;
                if (!i_cfg.bias_grad_en) begin
                    o_cmd.status = llfb_pkg::STATUS_DISABLED;
                end else if (llfb_pkg::SIZE_W'(i_in_data.second_index) >= w_nc) begin
                    o_cmd.status = llfb_pkg::STATUS_RANGE;
                end
                o_cmd.addr_g = w_b;
                o_cmd.count  = w_nr;
            end
        endcase
    end

endmodule

@@ src/llfb_queue.sv @@
// ----------------------------------------------------------------------------
// llfb_queue
// Short command queue between front and back, so each side stalls alone.
// ----------------------------------------------------------------------------
`include "linear_layer_forward_backward_defines.svh"

module llfb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  llfb_pkg::t_cmd        i_push_data,
    input  logic                  i_pop,
    output llfb_pkg::t_cmd        o_head,
    output llfb_pkg::t_queue_stat o_stat
);

    llfb_pkg::t_cmd                r_slot [llfb_pkg::QDEPTH];
    logic [llfb_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [llfb_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [llfb_pkg::QCNT_W-1:0]   r_count;

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == llfb_pkg::QCNT_W'(llfb_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + llfb_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + llfb_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + llfb_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - llfb_pkg::QCNT_W'(1);
            end
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    `LLFB_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full || i_pop, "command queue overflow")
    `LLFB_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, !o_stat.empty, "pop from empty command queue")

endmodule

@@ src/llfb_back.sv @@
// ----------------------------------------------------------------------------
// llfb_back
// Holds the four element stores, carries out loads, walks the stores with
// one multiply-accumulate per cycle for reads and registers the result.
// ----------------------------------------------------------------------------
`include "linear_layer_forward_backward_defines.svh"

module llfb_back #(
    parameter int MAX_ROWS    = llfb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = llfb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_INNER   = llfb_pkg::MAX_INNER_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  llfb_pkg::t_cmd        i_head,
    input  llfb_pkg::t_queue_stat i_queue,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output llfb_pkg::t_out_item   o_out_data
);

    localparam int XD  = MAX_ROWS * MAX_INNER;
    localparam int WD  = MAX_INNER * MAX_COLUMNS;
    localparam int GD  = MAX_ROWS * MAX_COLUMNS;
    localparam int BD  = MAX_COLUMNS;
    localparam int XAW = (XD > 1) ? $clog2(XD) : 1;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int GAW = (GD > 1) ? $clog2(GD) : 1;
    localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

    localparam logic [XAW-1:0] X_ROW_STEP = XAW'(MAX_INNER);
    localparam logic [WAW-1:0] W_ROW_STEP = WAW'(MAX_COLUMNS);
    localparam logic [GAW-1:0] G_ROW_STEP = GAW'(MAX_COLUMNS);

    localparam logic signed [llfb_pkg::ACC_W-1:0] SAT_HI = 2147483647;
    localparam logic signed [llfb_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_BIAS  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic signed [llfb_pkg::VALUE_W-1:0] r_mem_x [XD];
    logic signed [llfb_pkg::VALUE_W-1:0] r_mem_w [WD];
    logic signed [llfb_pkg::VALUE_W-1:0] r_mem_g [GD];
    logic signed [llfb_pkg::VALUE_W-1:0] r_mem_b [BD];

    logic [2:0]                           r_state;
    logic [llfb_pkg::SIZE_W-1:0]          r_cnt;
    logic                                 r_v1;
    logic                                 r_v2;
    logic                                 r_out_valid;
    llfb_pkg::t_cmd                       r_cmd;
    llfb_pkg::t_out_item                  r_out;
    logic [XAW-1:0]                       r_addr_x;
    logic [WAW-1:0]                       r_addr_w;
    logic [GAW-1:0]                       r_addr_g;
    logic [BAW-1:0]                       r_addr_b;
    logic signed [llfb_pkg::VALUE_W-1:0]  r_xq;
    logic signed [llfb_pkg::VALUE_W-1:0]  r_wq;
    logic signed [llfb_pkg::VALUE_W-1:0]  r_gq;
    logic signed [llfb_pkg::VALUE_W-1:0]  r_bq;
    logic signed [llfb_pkg::PROD_W-1:0]   r_prod;
    logic signed [llfb_pkg::ACC_W-1:0]    r_acc;

    logic                                 w_out_free;
    logic                                 w_head_read;
    logic                                 w_head_err;
    logic                                 w_load_err;
    logic                                 w_start;
    logic                                 w_load_ok;
    logic                                 w_last;
    logic                                 w_we;
    logic signed [llfb_pkg::VALUE_W-1:0]  w_op_a;
    logic signed [llfb_pkg::VALUE_W-1:0]  w_op_b;
    logic signed [llfb_pkg::ACC_W-1:0]    w_bias_term;
    logic signed [llfb_pkg::RESULT_W-1:0] w_sat;

    // Pop control: only while idle; loads and good reads go, errored reads need a free output slot
    always_comb begin
        w_out_free  = !r_out_valid || i_out_ready;
        w_head_read = (i_head.kind >= llfb_pkg::KIND_READ_Y);
        w_head_err  = (i_head.status != llfb_pkg::STATUS_OK);
        o_pop       = (r_state == ST_IDLE) && !i_queue.empty &&
                      (!w_head_read || !w_head_err || w_out_free);
        w_load_err  = o_pop && w_head_read && w_head_err;
        w_start     = o_pop && w_head_read && !w_head_err;
        w_we        = o_pop && !w_head_read && i_head.store_we;
        w_load_ok   = (r_state == ST_OUT) && w_out_free;
        w_last      = (r_cnt == (r_cmd.count - llfb_pkg::SIZE_W'(1)));
    end

    // Store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_we && (i_head.kind == llfb_pkg::KIND_LOAD_X)) begin
            r_mem_x[i_head.addr_x[XAW-1:0]] <= i_head.value;
        end
        r_xq <= r_mem_x[r_addr_x];
    end

    always_ff @(posedge i_clk) begin
        if (w_we && (i_head.kind == llfb_pkg::KIND_LOAD_W)) begin
            r_mem_w[i_head.addr_w[WAW-1:0]] <= i_head.value;
        end
        r_wq <= r_mem_w[r_addr_w];
    end

    always_ff @(posedge i_clk) begin
        if (w_we && (i_head.kind == llfb_pkg::KIND_LOAD_G)) begin
            r_mem_g[i_head.addr_g[GAW-1:0]] <= i_head.value;
        end
        r_gq <= r_mem_g[r_addr_g];
    end

    always_ff @(posedge i_clk) begin
        if (w_we && (i_head.kind == llfb_pkg::KIND_LOAD_B)) begin
            r_mem_b[i_head.addr_w[BAW-1:0]] <= i_head.value;
        end
        r_bq <= r_mem_b[r_addr_b];
    end

    // Sequencer and valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_WALK);
            r_v2 <= r_v1;
            if (w_load_err || w_load_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= ST_WALK;
                        r_cnt   <= '0;
                    end
                end
                ST_WALK: begin
                    r_cnt <= r_cnt + llfb_pkg::SIZE_W'(1);
                    if (w_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= ST_BIAS;
                    end
                end
                ST_BIAS: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Pick multiplier operands for the request kind
    always_comb begin
        case (r_cmd.kind)
            llfb_pkg::KIND_READ_Y: begin
                w_op_a = r_xq;
                w_op_b = r_wq;
            end
            llfb_pkg::KIND_READ_DX: begin
                w_op_a = r_gq;
                w_op_b = r_wq;
            end
            llfb_pkg::KIND_READ_DW: begin
                w_op_a = r_xq;
                w_op_b = r_gq;
            end
            default: begin
                w_op_a = r_gq;
                w_op_b = llfb_pkg::Q88_ONE;
            end
        endcase
        w_bias_term = llfb_pkg::ACC_W'(r_bq) <<< 8;
    end

    // Saturate the exact sum to signed 32 bits
    always_comb begin
        if (r_acc > SAT_HI) begin
            w_sat = SAT_HI[llfb_pkg::RESULT_W-1:0];
        end else if (r_acc < SAT_LO) begin
            w_sat = SAT_LO[llfb_pkg::RESULT_W-1:0];
        end else begin
            w_sat = r_acc[llfb_pkg::RESULT_W-1:0];
        end
    end

    // Walk addresses, product and accumulator
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd    <= i_head;
            r_addr_x <= i_head.addr_x[XAW-1:0];
            r_addr_w <= i_head.addr_w[WAW-1:0];
            r_addr_g <= i_head.addr_g[GAW-1:0];
            r_addr_b <= i_head.addr_w[BAW-1:0];
        end else if (r_state == ST_WALK) begin
            case (r_cmd.kind)
                llfb_pkg::KIND_READ_Y: begin
                    r_addr_x <= r_addr_x + XAW'(1);
                    r_addr_w <= r_addr_w + W_ROW_STEP;
                end
                llfb_pkg::KIND_READ_DX: begin
                    r_addr_g <= r_addr_g + GAW'(1);
                    r_addr_w <= r_addr_w + WAW'(1);
                end
                llfb_pkg::KIND_READ_DW: begin
                    r_addr_x <= r_addr_x + X_ROW_STEP;
                    r_addr_g <= r_addr_g + G_ROW_STEP;
                end
                default: begin
                    r_addr_g <= r_addr_g + G_ROW_STEP;
                end
            endcase
        end

        r_prod <= w_op_a * w_op_b;

        if (o_pop) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + llfb_pkg::ACC_W'(r_prod);
        end else if ((r_state == ST_BIAS) && (r_cmd.kind == llfb_pkg::KIND_READ_Y)) begin
            r_acc <= r_acc + w_bias_term;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_load_err) begin
            r_out.result_value <= '0;
            r_out.status       <= i_head.status;
            r_out.echo_first   <= i_head.echo_first;
            r_out.echo_second  <= i_head.echo_second;
        end else if (w_load_ok) begin
            r_out.result_value <= w_sat;
            r_out.status       <= llfb_pkg::STATUS_OK;
            r_out.echo_first   <= r_cmd.echo_first;
            r_out.echo_second  <= r_cmd.echo_second;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LLFB_ASSERT_IMPLY(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE, "command popped while busy")
    `LLFB_ASSERT_IMPLY(a_bias_drained, i_clk, i_rst_n, r_state == ST_BIAS, !r_v1 && !r_v2, "bias added with products in flight")
    `LLFB_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_load_ok, r_out_valid && (r_state == ST_IDLE), "finished read not registered")

endmodule

@@ src/linear_layer_forward_backward.sv @@
// ----------------------------------------------------------------------------
// Linear layer engine, forward and backward
// Holds the configuration registers and joins front, queue and back.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid/o_in_ready. Kinds 0..3 load one Q8.8 element
// of X, W, b or G and give no result; kinds 4..7 read one element of Y, dX,
// dW or db and give one result on o_out_valid/i_out_ready (Q16.16,
// saturated, with status and echoed indices).
// The front checks and classifies a request in its accept cycle and places
// a command in a four-entry queue. The back pops one command at a time: a
// load is written to its store as it is popped; a read walks n stored pairs,
// one multiply-accumulate per cycle through one read port per store, with n
// the inner size for Y, the column count for dX and the row count for dW and
// db. A read's result is registered after the walk, the product pipeline and
// the bias step, before the next pop; a refused read is registered on its pop.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data at once.
// Reset clears the registers to sizes of one and gradients disabled, and
// empties queue and output; store contents stay undefined until loaded.
// While the receiver stalls, the finished result is held, the back waits
// with its next result, and requests fill the queue before ready drops.
// ----------------------------------------------------------------------------
module linear_layer_forward_backward #(
    parameter int MAX_ROWS    = llfb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = llfb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_INNER   = llfb_pkg::MAX_INNER_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [llfb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [llfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  llfb_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output llfb_pkg::t_out_item                o_out_data
);

    llfb_pkg::t_cfg        r_cfg;
    llfb_pkg::t_cmd        w_push_cmd;
    llfb_pkg::t_cmd        w_head;
    llfb_pkg::t_queue_stat w_queue;
    logic                  w_push;
    logic                  w_pop;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows         <= llfb_pkg::SIZE_W'(1);
            r_cfg.columns      <= llfb_pkg::SIZE_W'(1);
            r_cfg.inner        <= llfb_pkg::SIZE_W'(1);
            r_cfg.in_grad_en   <= 1'b0;
            r_cfg.wt_grad_en   <= 1'b0;
            r_cfg.bias_grad_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                llfb_pkg::CFG_ROWS:         r_cfg.rows         <= i_cfg_data;
                llfb_pkg::CFG_COLUMNS:      r_cfg.columns      <= i_cfg_data;
                llfb_pkg::CFG_INNER:        r_cfg.inner        <= i_cfg_data;
                llfb_pkg::CFG_IN_GRAD_EN:   r_cfg.in_grad_en   <= i_cfg_data[0];
                llfb_pkg::CFG_WT_GRAD_EN:   r_cfg.wt_grad_en   <= i_cfg_data[0];
                llfb_pkg::CFG_BIAS_GRAD_EN: r_cfg.bias_grad_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    llfb_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_INNER   (MAX_INNER)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_queue    (w_queue),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    llfb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cmd),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_queue)
    );

    llfb_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_INNER   (MAX_INNER)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_queue     (w_queue),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: fully connected layer engine testbench
// Loads X, W, b and G one element at a time and reads back single elements of
// Y, dX, dW and db. A local copy of the layer predicts each read; results are
// compared field by field. The sender and receiver idle at random, and the
// receiver holds off at times to fill the engine's command queue.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import llfb_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int SETTLE      = 40;
    localparam int LONG_HOLD   = 400;
    localparam int TIMEOUT_NS  = 3_000_000;
    localparam int ROW_STRIDE  = MAX_INNER_DEF;
    localparam int COL_STRIDE  = MAX_COLUMNS_DEF;

    // Register indexes outside the defined list
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_mode;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    t_in_item                i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out_item               o_out_data;

    // Layer copy: configuration and the four stores
    t_cfg                    cfg_copy;
    logic signed [15:0]      x_copy [MAX_ROWS_DEF*MAX_INNER_DEF];
    logic signed [15:0]      w_copy [MAX_INNER_DEF*MAX_COLUMNS_DEF];
    logic signed [15:0]      b_copy [MAX_COLUMNS_DEF];
    logic signed [15:0]      g_copy [MAX_ROWS_DEF*MAX_COLUMNS_DEF];

    // Entries already given a load request, tracked as requests are queued
    bit                      x_loaded [MAX_ROWS_DEF*MAX_INNER_DEF];
    bit                      w_loaded [MAX_INNER_DEF*MAX_COLUMNS_DEF];
    bit                      b_loaded [MAX_COLUMNS_DEF];
    bit                      g_loaded [MAX_ROWS_DEF*MAX_COLUMNS_DEF];

    t_in_item                pending_requests [$];
    t_out_item               expected_elements [$];

    logic [KIND_W-1:0] load_kinds [4] = '{KIND_LOAD_X, KIND_LOAD_W, KIND_LOAD_B, KIND_LOAD_G};
    logic [KIND_W-1:0] read_kinds [4] = '{KIND_READ_Y, KIND_READ_DX, KIND_READ_DW,
                                          KIND_READ_DB};

    int          errors              = 0;
    int          requests_queued     = 0;
    int          loads_accepted      = 0;
    int          reads_accepted      = 0;
    int          results_checked     = 0;
    int          shapes_used         = 0;
    int          hold_offs_requested = 0;
    int          hold_offs_done      = 0;
    int          burst_left          = 1;
    int          gap_left            = 0;
    int          hold_left           = 0;
    int          mode_left           = 0;
    int          cycle_count         = 0;
    t_ready_mode ready_mode          = READY_ALWAYS;

    linear_layer_forward_backward dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Size in use: zero counts as one, anything above the store size as the maximum
    function automatic int eff_size(input logic [SIZE_W-1:0] v, input int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic logic [STATUS_W-1:0] read_status(input logic [KIND_W-1:0] kind,
                                                        input int a, input int b);
        int nr, nc, nk;
        nr = eff_size(cfg_copy.rows, MAX_ROWS_DEF);
        nc = eff_size(cfg_copy.columns, MAX_COLUMNS_DEF);
        nk = eff_size(cfg_copy.inner, MAX_INNER_DEF);
        case (kind)
            KIND_READ_Y: begin
                return (a >= nr || b >= nc) ? STATUS_RANGE : STATUS_OK;
            end
            KIND_READ_DX: begin
                if (!cfg_copy.in_grad_en) return STATUS_DISABLED;
                return (a >= nr || b >= nk) ? STATUS_RANGE : STATUS_OK;
            end
            KIND_READ_DW: begin
                if (!cfg_copy.wt_grad_en) return STATUS_DISABLED;
                return (a >= nk || b >= nc) ? STATUS_RANGE : STATUS_OK;
            end
            default: begin
                if (!cfg_copy.bias_grad_en) return STATUS_DISABLED;
                return (b >= nc) ? STATUS_RANGE : STATUS_OK;
            end
        endcase
    endfunction

    // Apply one accepted request to the layer copy; reads queue their element
    task automatic layer_apply(input t_in_item req);
        t_out_item          res;
        logic signed [63:0] sum;
        int                 nr, nc, nk, a, b, t;
        nr  = eff_size(cfg_copy.rows, MAX_ROWS_DEF);
        nc  = eff_size(cfg_copy.columns, MAX_COLUMNS_DEF);
        nk  = eff_size(cfg_copy.inner, MAX_INNER_DEF);
        a   = int'(req.first_index);
        b   = int'(req.second_index);
        sum = '0;
        case (req.kind)
            KIND_LOAD_X: x_copy[a*ROW_STRIDE + b] = req.value;
            KIND_LOAD_W: w_copy[a*COL_STRIDE + b] = req.value;
            KIND_LOAD_B: b_copy[b] = req.value;
            KIND_LOAD_G: g_copy[a*COL_STRIDE + b] = req.value;
            default: begin
                res.status      = read_status(req.kind, a, b);
                res.echo_first  = (req.kind == KIND_READ_DB) ? '0 : req.first_index;
                res.echo_second = req.second_index;
                if (res.status == STATUS_OK) begin
                    case (req.kind)
                        KIND_READ_Y: begin
                            for (t = 0; t < nk; t++)
                                sum += x_copy[a*ROW_STRIDE + t] * w_copy[t*COL_STRIDE + b];
                            sum += b_copy[b] * Q88_ONE;
                        end
                        KIND_READ_DX: begin
                            for (t = 0; t < nc; t++)
                                sum += g_copy[a*COL_STRIDE + t] * w_copy[b*COL_STRIDE + t];
                        end
                        KIND_READ_DW: begin
                            for (t = 0; t < nr; t++)
                                sum += x_copy[t*ROW_STRIDE + a] * g_copy[t*COL_STRIDE + b];
                        end
                        default: begin
                            for (t = 0; t < nr; t++)
                                sum += g_copy[t*COL_STRIDE + b] * Q88_ONE;
                        end
                    endcase
                end
                // Saturate once, at the end, to signed 32 bits
                if (res.status != STATUS_OK)
                    res.result_value = '0;
                else if (sum > 64'sd2147483647)
                    res.result_value = 32'sh7FFF_FFFF;
                else if (sum < -64'sd2147483648)
                    res.result_value = 32'sh8000_0000;
                else
                    res.result_value = sum[31:0];
                expected_elements = {expected_elements, res};
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Driver: offer queued requests in bursts with random gaps
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                layer_apply(i_in_data);
                if (i_in_data.kind inside {KIND_LOAD_X, KIND_LOAD_W, KIND_LOAD_B, KIND_LOAD_G})
                    loads_accepted++;
                else
                    reads_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_requests.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: begin
                                burst_left = $urandom_range(1, 12);
                                gap_left   = 0;
                            end
                            8: begin
                                burst_left = $urandom_range(1, 6);
                                gap_left   = $urandom_range(5, 20);
                            end
                            9: begin
                                burst_left = 40;
                                gap_left   = 0;
                            end
                            default: begin
                                burst_left = $urandom_range(1, 12);
                                gap_left   = $urandom_range(1, 4);
                            end
                        endcase
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expected element, then
    // pick the next ready value from the current stall pattern
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            cycle_count++;
            if (o_out_valid && i_out_ready) begin
                if (expected_elements.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual value %0d status %0d",
                             $time, o_out_data.result_value, o_out_data.status);
                end else begin
                    want = expected_elements.pop_front();
                    compare_field("result_value", want.result_value, o_out_data.result_value);
                    compare_field("status", want.status, o_out_data.status);
                    compare_field("echo_first", want.echo_first, o_out_data.echo_first);
                    compare_field("echo_second", want.echo_second, o_out_data.echo_second);
                    results_checked++;
                end
            end
            if (mode_left == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_offs_done < hold_offs_requested) begin
                hold_left = LONG_HOLD - 1;
                hold_offs_done++;
                i_out_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS:   i_out_ready <= 1'b1;
                    READY_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
                    READY_PERIODIC: i_out_ready <= (cycle_count % 7) < 3;
                endcase
            end
        end
    end

    function automatic logic signed [15:0] rand_q88();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic push_load(input logic [KIND_W-1:0] kind, input int a, input int b,
                             input logic signed [15:0] value);
        t_in_item req;
        req.kind         = kind;
        req.first_index  = INDEX_W'(a);
        req.second_index = INDEX_W'(b);
        req.value        = value;
        case (kind)
            KIND_LOAD_X: x_loaded[a*ROW_STRIDE + b] = 1'b1;
            KIND_LOAD_W: w_loaded[a*COL_STRIDE + b] = 1'b1;
            KIND_LOAD_B: b_loaded[b] = 1'b1;
            default:     g_loaded[a*COL_STRIDE + b] = 1'b1;
        endcase
        pending_requests = {pending_requests, req};
        requests_queued++;
    endtask

    // Load an entry with a random value unless it already has one
    task automatic ensure_loaded(input logic [KIND_W-1:0] kind, input int r, input int c);
        bit missing;
        case (kind)
            KIND_LOAD_X: missing = !x_loaded[r*ROW_STRIDE + c];
            KIND_LOAD_W: missing = !w_loaded[r*COL_STRIDE + c];
            KIND_LOAD_B: missing = !b_loaded[c];
            default:     missing = !g_loaded[r*COL_STRIDE + c];
        endcase
        if (missing)
            push_load(kind, r, c, rand_q88());
    endtask

    // Queue a read; an in-range read is preceded by loads of the entries its walk would touch that have none yet
    task automatic queue_read(input logic [KIND_W-1:0] kind, input int a, input int b);
        t_in_item req;
        int       nr, nc, nk, t;
        nr = eff_size(cfg_copy.rows, MAX_ROWS_DEF);
        nc = eff_size(cfg_copy.columns, MAX_COLUMNS_DEF);
        nk = eff_size(cfg_copy.inner, MAX_INNER_DEF);
        if (read_status(kind, a, b) == STATUS_OK) begin
            case (kind)
                KIND_READ_Y: begin
                    for (t = 0; t < nk; t++) begin
                        ensure_loaded(KIND_LOAD_X, a, t);
                        ensure_loaded(KIND_LOAD_W, t, b);
                    end
                    ensure_loaded(KIND_LOAD_B, $urandom_range(0, 15), b);
                end
                KIND_READ_DX: begin
                    for (t = 0; t < nc; t++) begin
                        ensure_loaded(KIND_LOAD_G, a, t);
                        ensure_loaded(KIND_LOAD_W, b, t);
                    end
                end
                KIND_READ_DW: begin
                    for (t = 0; t < nr; t++) begin
                        ensure_loaded(KIND_LOAD_X, t, a);
                        ensure_loaded(KIND_LOAD_G, t, b);
                    end
                end
                default: begin
                    for (t = 0; t < nr; t++)
                        ensure_loaded(KIND_LOAD_G, t, b);
                end
            endcase
        end
        req.kind         = kind;
        req.first_index  = INDEX_W'(a);
        req.second_index = INDEX_W'(b);
        req.value        = VALUE_W'($urandom);
        pending_requests = {pending_requests, req};
        requests_queued++;
    endtask

    task automatic random_request();
        logic [KIND_W-1:0] kind;
        int                pick, nr, nc, nk;
        nr   = eff_size(cfg_copy.rows, MAX_ROWS_DEF);
        nc   = eff_size(cfg_copy.columns, MAX_COLUMNS_DEF);
        nk   = eff_size(cfg_copy.inner, MAX_INNER_DEF);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // Read inside the shape in use
            kind = read_kinds[$urandom_range(0, 3)];
            case (kind)
                KIND_READ_Y:  queue_read(kind, $urandom_range(0, nr-1), $urandom_range(0, nc-1));
                KIND_READ_DX: queue_read(kind, $urandom_range(0, nr-1), $urandom_range(0, nk-1));
                KIND_READ_DW: queue_read(kind, $urandom_range(0, nk-1), $urandom_range(0, nc-1));
                default:      queue_read(kind, $urandom_range(0, 15), $urandom_range(0, nc-1));
            endcase
        end else if (pick < 80) begin
            push_load(load_kinds[$urandom_range(0, 3)], $urandom_range(0, 15),
                      $urandom_range(0, 15), rand_q88());
        end else begin
            queue_read(read_kinds[$urandom_range(0, 3)], $urandom_range(0, 15),
                       $urandom_range(0, 15));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_ROWS:         cfg_copy.rows         = data;
            CFG_COLUMNS:      cfg_copy.columns      = data;
            CFG_INNER:        cfg_copy.inner        = data;
            CFG_IN_GRAD_EN:   cfg_copy.in_grad_en   = data[0];
            CFG_WT_GRAD_EN:   cfg_copy.wt_grad_en   = data[0];
            CFG_BIAS_GRAD_EN: cfg_copy.bias_grad_en = data[0];
            default: ;
        endcase
    endtask

    task automatic set_layer(input int rows, input int cols, input int inner,
                             input bit in_en, input bit wt_en, input bit bias_en);
        write_reg(CFG_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_COLUMNS, CFG_DATA_W'(cols));
        write_reg(CFG_INNER, CFG_DATA_W'(inner));
        write_reg(CFG_IN_GRAD_EN, CFG_DATA_W'(in_en));
        write_reg(CFG_WT_GRAD_EN, CFG_DATA_W'(wt_en));
        write_reg(CFG_BIAS_GRAD_EN, CFG_DATA_W'(bias_en));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shapes_used++;
    endtask

    // Wait for the queue to drain and every element to return, then let
    // any trailing loads finish inside the engine
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_elements.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_phase(input int rows, input int cols, input int inner,
                             input bit in_en, input bit wt_en, input bit bias_en,
                             input int count, input bit hold_off);
        int stop_at;
        set_layer(rows, cols, inner, in_en, wt_en, bias_en);
        if (hold_off)
            hold_offs_requested++;
        stop_at = requests_queued + count;
        while (requests_queued < stop_at)
            random_request();
        wait_idle();
    endtask

    initial begin : stimulus
        int i;
        cfg_copy = '{rows: 5'd1, columns: 5'd1, inner: 5'd1,
                     in_grad_en: 1'b0, wt_grad_en: 1'b0, bias_grad_en: 1'b0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 3x3x3 layer, all gradients on; spare register indexes ignored
        write_reg(CFG_SPARE_LO, 5'd0);
        write_reg(CFG_SPARE_HI, 5'd31);
        set_layer(3, 3, 3, 1'b1, 1'b1, 1'b1);

        // Forward read saturating high
        for (i = 0; i < 3; i++) push_load(KIND_LOAD_X, 0, i, 16'sh8000);
        for (i = 0; i < 3; i++) push_load(KIND_LOAD_W, i, 0, 16'sh8000);
        push_load(KIND_LOAD_B, 5, 0, 16'sh7FFF);
        queue_read(KIND_READ_Y, 0, 0);

        // Input gradient saturating low
        push_load(KIND_LOAD_W, 0, 1, 16'sh8000);
        push_load(KIND_LOAD_W, 0, 2, 16'sh8000);
        for (i = 0; i < 3; i++) push_load(KIND_LOAD_G, 0, i, 16'sh7FFF);
        queue_read(KIND_READ_DX, 0, 0);

        // Bias gradient (row index echoed as zero) and weight gradient
        push_load(KIND_LOAD_G, 1, 0, 16'sh8000);
        push_load(KIND_LOAD_G, 2, 0, 16'sh8000);
        queue_read(KIND_READ_DB, 9, 0);
        push_load(KIND_LOAD_X, 1, 0, 16'sh7FFF);
        push_load(KIND_LOAD_X, 2, 0, 16'sh0001);
        queue_read(KIND_READ_DW, 0, 0);

        // Indices beyond the shape in use
        queue_read(KIND_READ_Y, 3, 0);
        queue_read(KIND_READ_DX, 0, 3);
        queue_read(KIND_READ_DW, 3, 0);
        queue_read(KIND_READ_DB, 15, 15);
        wait_idle();

        // Gradients off: disabled status wins over bad indices
        set_layer(3, 3, 3, 1'b0, 1'b0, 1'b0);
        queue_read(KIND_READ_DX, 15, 15);
        queue_read(KIND_READ_DW, 15, 15);
        queue_read(KIND_READ_DB, 15, 15);
        queue_read(KIND_READ_Y, 0, 0);
        wait_idle();

        // Random: extreme shapes, clamped register values, then small shapes
        run_phase(1, 1, 1, 1'b1, 1'b1, 1'b1, 60, 1'b0);
        run_phase(16, 16, 16, 1'b1, 1'b1, 1'b1, 90, 1'b1);
        run_phase(0, 31, 5, 1'b0, 1'b1, 1'b1, 70, 1'b0);
        run_phase(17, 0, 31, 1'b1, 1'b0, 1'b1, 70, 1'b0);
        for (i = 0; i < 5; i++)
            run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 70, i == 2);

        $display("Run covered %0d loads and %0d element reads over %0d layer shapes.",
                 loads_accepted, reads_accepted, shapes_used);
        $display("Compared %0d results; receiver held off %0d times for %0d cycles.",
                 results_checked, hold_offs_done, LONG_HOLD);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d requests and %0d results outstanding.",
                 pending_requests.size(), expected_elements.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/llfb_pkg.sv
src/llfb_front.sv
src/llfb_queue.sv
src/llfb_back.sv
src/linear_layer_forward_backward.sv
dv/tb_top.sv
